[design/twsr_pkg.sv]
// ----------------------------------------------------------------------------
// Timing wheel slot ring package
// Shared codes, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package twsr_pkg;

    localparam int SLOTS_DEFAULT  = 64;
    localparam int TIMERS_DEFAULT = 32;

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 6;
    localparam int ID_W    = 5;
    localparam int KIND_W  = 3;
    localparam int LEVEL_W = 8;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK = 3'd2;
    localparam logic [OP_W-1:0] OP_PRST = 3'd3;
    localparam logic [OP_W-1:0] OP_CLR  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd5;

    localparam logic [1:0] ADDR_SLOT = 2'd0;
    localparam logic [1:0] ADDR_CUR  = 2'd1;
    localparam logic [1:0] ADDR_NEXT = 2'd2;
    localparam logic [1:0] ADDR_CNT  = 2'd3;

    localparam logic [1:0] IDSEL_REQ  = 2'd0;
    localparam logic [1:0] IDSEL_W0   = 2'd1;
    localparam logic [1:0] IDSEL_W1   = 2'd2;
    localparam logic [1:0] IDSEL_ZERO = 2'd3;

    typedef struct packed {
        logic              cap_in;
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic              wr_zero;
        logic              lat0;
        logic              lat1;
        logic              pop0;
        logic              pop1;
        logic              cnt_inc;
        logic              cnt_clr;
        logic              ptr_adv;
        logic              ptr_zero;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic [1:0]        id_sel;
        logic              emit_last;
        logic              emit_wrap;
    } twsr_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic [OP_W-1:0] op;
        logic            add_ok;
        logic            del_ok;
        logic            cnt_last;
        logic            w0_nz;
        logic            w0_single;
        logic            w1_nz;
        logic            w1_single;
        logic            can_load;
    } twsr_status_t;

    function automatic logic [ID_W-1:0] lowest_set(input logic [31:0] w);
        logic [ID_W-1:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (w[i])
            begin
                idx = ID_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[design/twsr_ctrl.sv]
// ----------------------------------------------------------------------------
// Timing wheel slot ring controller
// Sequences memory accesses and result requests for each input request.
// ----------------------------------------------------------------------------
module twsr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  twsr_pkg::twsr_status_t sts,
    output twsr_pkg::twsr_cmd_t    cmd
);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_LAT0 = 3'd4;
    localparam logic [2:0] ST_LAT1 = 3'd5;
    localparam logic [2:0] ST_FIRE = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;
    localparam logic [2:0] ST_CLR  = 3'd0;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       clr_reg;
    logic       clr_next;
    logic       fire_last;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        if (sts.w0_nz)
        begin
            fire_last = sts.w0_single && !sts.w1_nz;
        end
        else if (sts.w1_nz)
        begin
            fire_last = sts.w1_single;
        end
        else
        begin
            fire_last = 1'b1;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = twsr_pkg::ADDR_CNT;
                cmd.wr_zero = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = clr_reg ? ST_DONE : ST_IDLE;
                    clr_next   = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_in  = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                    if (sts.in_op == twsr_pkg::OP_ADD || sts.in_op == twsr_pkg::OP_DEL ||
                        sts.in_op == twsr_pkg::OP_TICK)
                    begin
                        state_next = ST_RD;
                    end
                    else if (sts.in_op == twsr_pkg::OP_PRST)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (sts.in_op == twsr_pkg::OP_CLR)
                    begin
                        state_next = ST_CLR;
                        clr_next   = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_en = 1'b1;
                if (sts.op == twsr_pkg::OP_TICK)
                begin
                    cmd.rd_sel = twsr_pkg::ADDR_CUR;
                    state_next = ST_LAT0;
                end
                else
                begin
                    cmd.rd_sel = twsr_pkg::ADDR_SLOT;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (sts.can_load)
                begin
                    cmd.emit      = 1'b1;
                    cmd.id_sel    = twsr_pkg::IDSEL_REQ;
                    cmd.emit_last = 1'b1;
                    cmd.wr_sel    = twsr_pkg::ADDR_SLOT;
                    if (sts.op == twsr_pkg::OP_ADD)
                    begin
                        cmd.wr_en     = sts.add_ok;
                        cmd.emit_kind = sts.add_ok ? twsr_pkg::KIND_ADDED
                                                   : twsr_pkg::KIND_REFUSED;
                    end
                    else
                    begin
                        cmd.wr_en     = sts.del_ok;
                        cmd.emit_kind = twsr_pkg::KIND_DELETED;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_LAT0:
            begin
                cmd.lat0    = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = twsr_pkg::ADDR_CUR;
                cmd.wr_zero = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = twsr_pkg::ADDR_NEXT;
                state_next  = ST_LAT1;
            end
            ST_LAT1:
            begin
                cmd.lat1    = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = twsr_pkg::ADDR_NEXT;
                cmd.wr_zero = 1'b1;
                state_next  = ST_FIRE;
            end
            ST_FIRE:
            begin
                if (sts.can_load)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_wrap = 1'b1;
                    cmd.emit_last = fire_last;
                    if (sts.w0_nz)
                    begin
                        cmd.emit_kind = twsr_pkg::KIND_FIRED;
                        cmd.id_sel    = twsr_pkg::IDSEL_W0;
                        cmd.pop0      = 1'b1;
                    end
                    else if (sts.w1_nz)
                    begin
                        cmd.emit_kind = twsr_pkg::KIND_FIRED;
                        cmd.id_sel    = twsr_pkg::IDSEL_W1;
                        cmd.pop1      = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_kind = twsr_pkg::KIND_NONE;
                        cmd.id_sel    = twsr_pkg::IDSEL_ZERO;
                    end
                    if (fire_last)
                    begin
                        cmd.ptr_adv = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                if (sts.can_load)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = twsr_pkg::KIND_DONE;
                    cmd.id_sel    = twsr_pkg::IDSEL_ZERO;
                    cmd.emit_last = 1'b1;
                    cmd.ptr_zero  = (sts.op == twsr_pkg::OP_PRST);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            clr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

endmodule

[design/twsr_dp.sv]
// ----------------------------------------------------------------------------
// Timing wheel slot ring datapath
// Slot bitmap memory, pointer, firing words and the result register.
// ----------------------------------------------------------------------------
module twsr_dp
#(
    parameter int SLOTS  = twsr_pkg::SLOTS_DEFAULT,
    parameter int TIMERS = twsr_pkg::TIMERS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [twsr_pkg::OP_W-1:0]       opcode,
    input  logic [twsr_pkg::SLOT_W-1:0]     slot,
    input  logic [twsr_pkg::ID_W-1:0]       tmr_id,
    input  logic                            cfg_valid,
    input  logic [twsr_pkg::LEVEL_W-1:0]    cfg_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [twsr_pkg::KIND_W-1:0]     kind,
    output logic [twsr_pkg::ID_W-1:0]       fired_id,
    output logic [twsr_pkg::LEVEL_W-1:0]    level_tag,
    output logic                            wrapped,
    output logic                            last,
    input  twsr_pkg::twsr_cmd_t             cmd,
    output twsr_pkg::twsr_status_t          sts
);

    localparam int AW = $clog2(SLOTS);

    logic [TIMERS-1:0] mem [SLOTS];

    logic [twsr_pkg::OP_W-1:0]    op_reg;
    logic [twsr_pkg::SLOT_W-1:0]  slot_reg;
    logic [twsr_pkg::ID_W-1:0]    id_reg;
    logic [twsr_pkg::LEVEL_W-1:0] ring_reg;
    logic [AW-1:0]                ptr_reg;
    logic [AW-1:0]                cnt_reg;
    logic [TIMERS-1:0]            rdata_reg;
    logic [TIMERS-1:0]            w0_reg;
    logic [TIMERS-1:0]            w1_reg;
    logic                         out_valid_reg;
    logic [twsr_pkg::KIND_W-1:0]  kind_reg;
    logic [twsr_pkg::ID_W-1:0]    id_out_reg;
    logic [twsr_pkg::LEVEL_W-1:0] level_reg;
    logic                         wrap_reg;
    logic                         last_reg;

    logic [AW-1:0]           slot_addr;
    logic [AW-1:0]           ptr_next_slot;
    logic                    at_end;
    logic                    slot_ok;
    logic                    id_ok;
    logic [TIMERS-1:0]       mask;
    logic [TIMERS-1:0]       w0_pop;
    logic [TIMERS-1:0]       w1_pop;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [TIMERS-1:0]       wr_data;
    logic [twsr_pkg::ID_W-1:0] id_sel_val;

    assign slot_addr     = AW'(slot_reg);
    assign at_end        = (ptr_reg == AW'(SLOTS - 1));
    assign ptr_next_slot = at_end ? '0 : ptr_reg + AW'(1);
    assign slot_ok       = (32'(slot_reg) < 32'(SLOTS));
    assign id_ok         = (32'(id_reg) < 32'(TIMERS));
    assign mask          = TIMERS'(1) << id_reg;
    assign w0_pop        = w0_reg & (w0_reg - TIMERS'(1));
    assign w1_pop        = w1_reg & (w1_reg - TIMERS'(1));

    always_comb
    begin
        sts.in_op     = opcode;
        sts.op        = op_reg;
        sts.add_ok    = slot_ok && id_ok && ((slot_addr != ptr_reg) || (ring_reg == '0));
        sts.del_ok    = slot_ok && id_ok;
        sts.cnt_last  = (cnt_reg == AW'(SLOTS - 1));
        sts.w0_nz     = (w0_reg != '0);
        sts.w0_single = (w0_pop == '0);
        sts.w1_nz     = (w1_reg != '0);
        sts.w1_single = (w1_pop == '0);
        sts.can_load  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            twsr_pkg::ADDR_SLOT: rd_addr = slot_addr;
            twsr_pkg::ADDR_CUR:  rd_addr = ptr_reg;
            twsr_pkg::ADDR_NEXT: rd_addr = ptr_next_slot;
            default:             rd_addr = cnt_reg;
        endcase
        unique case (cmd.wr_sel)
            twsr_pkg::ADDR_SLOT: wr_addr = slot_addr;
            twsr_pkg::ADDR_CUR:  wr_addr = ptr_reg;
            twsr_pkg::ADDR_NEXT: wr_addr = ptr_next_slot;
            default:             wr_addr = cnt_reg;
        endcase
        if (cmd.wr_zero)
        begin
            wr_data = '0;
        end
        else if (op_reg == twsr_pkg::OP_ADD)
        begin
            wr_data = rdata_reg | mask;
        end
        else
        begin
            wr_data = rdata_reg & ~mask;
        end
        unique case (cmd.id_sel)
            twsr_pkg::IDSEL_REQ: id_sel_val = id_reg;
            twsr_pkg::IDSEL_W0:  id_sel_val = twsr_pkg::lowest_set(32'(w0_reg));
            twsr_pkg::IDSEL_W1:  id_sel_val = twsr_pkg::lowest_set(32'(w1_reg));
            default:             id_sel_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            op_reg   <= opcode;
            slot_reg <= slot;
            id_reg   <= tmr_id;
        end
        if (cmd.lat0)
        begin
            w0_reg <= rdata_reg;
        end
        else if (cmd.pop0)
        begin
            w0_reg <= w0_pop;
        end
        if (cmd.lat1)
        begin
            w1_reg <= rdata_reg;
        end
        else if (cmd.pop1)
        begin
            w1_reg <= w1_pop;
        end
        if (cmd.emit)
        begin
            kind_reg   <= cmd.emit_kind;
            id_out_reg <= id_sel_val;
            level_reg  <= ring_reg;
            wrap_reg   <= cmd.emit_wrap && at_end;
            last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            ring_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ring_reg <= cfg_data;
            end
            if (cmd.ptr_zero)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_adv)
            begin
                ptr_reg <= ptr_next_slot;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_id  = id_out_reg;
    assign level_tag = level_reg;
    assign wrapped   = wrap_reg;
    assign last      = last_reg;

endmodule

[design/timing_wheel_slot_ring.sv]
// ----------------------------------------------------------------------------
// Timing wheel slot ring
// One wheel level: a ring of slot bitmaps with add, delete, tick, pointer reset and clear.
// ----------------------------------------------------------------------------
// The block handles one request at a time through a slot memory with one read
// and one write port. A tick gives one result per fired timer, or a single
// nothing-fired result. A clear sweeps the memory one slot per cycle and then
// gives a done result. After reset the same sweep runs while input stays
// stalled; configuration writes are taken at any time.
module timing_wheel_slot_ring
#(
    parameter int SLOTS  = twsr_pkg::SLOTS_DEFAULT,
    parameter int TIMERS = twsr_pkg::TIMERS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [twsr_pkg::OP_W-1:0]    opcode,
    input  logic [twsr_pkg::SLOT_W-1:0]  slot,
    input  logic [twsr_pkg::ID_W-1:0]    tmr_id,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [twsr_pkg::KIND_W-1:0]  kind,
    output logic [twsr_pkg::ID_W-1:0]    fired_id,
    output logic [twsr_pkg::LEVEL_W-1:0] level_tag,
    output logic                         wrapped,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [twsr_pkg::LEVEL_W-1:0] cfg_data
);

    twsr_pkg::twsr_cmd_t    cmd;
    twsr_pkg::twsr_status_t sts;

    assign cfg_ready = 1'b1;

    twsr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    twsr_dp
    #(
        .SLOTS  (SLOTS),
        .TIMERS (TIMERS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .opcode    (opcode),
        .slot      (slot),
        .tmr_id    (tmr_id),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .fired_id  (fired_id),
        .level_tag (level_tag),
        .wrapped   (wrapped),
        .last      (last),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
